// ===== sv/hrg_pkg.sv =====
// shared types, region codes and gamma table for the hsv to rgb pipeline
package hrg_pkg;

  localparam int unsigned HUE_STEPS = 43;
  localparam int unsigned FRAC_MUL  = 6;
  localparam logic [7:0]  FULL      = 8'd255;

  // hue sector, one per 43 hue steps
  typedef enum logic [2:0] {
    RGN_RED_YEL = 3'd0,
    RGN_YEL_GRN = 3'd1,
    RGN_GRN_CYN = 3'd2,
    RGN_CYN_BLU = 3'd3,
    RGN_BLU_MAG = 3'd4,
    RGN_MAG_RED = 3'd5
  } hrg_region_t;

  typedef struct packed {
    logic       en;
    logic [7:0] k;
  } hrg_side_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    hrg_side_t  side;
  } hrg_px_t;

  localparam logic [7:0] GAMMA_ROM [256] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
    8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
    8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
    8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
    8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
    8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
    8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
    8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
    8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
    8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
    8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
    8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
    8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
    8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
    8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
    8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
    8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
    8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
    8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
    8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
    8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
    8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
    8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
    8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
  };

endpackage

// ===== sv/hrg_hsv_pipe.sv =====
// four-stage hsv to linear rgb pipeline: sector, fraction products, p/q/t, channel select
module hrg_hsv_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        hue,
  input  logic [7:0]        saturation,
  input  logic [7:0]        brightness,
  input  hrg_pkg::hrg_side_t side_in,
  output logic              out_valid,
  output hrg_pkg::hrg_px_t  out_px
);
  import hrg_pkg::*;

  localparam logic [7:0] B1 = 8'(HUE_STEPS);
  localparam logic [7:0] B2 = 8'(2 * HUE_STEPS);
  localparam logic [7:0] B3 = 8'(3 * HUE_STEPS);
  localparam logic [7:0] B4 = 8'(4 * HUE_STEPS);
  localparam logic [7:0] B5 = 8'(5 * HUE_STEPS);

  // stage 1 registers
  logic        s1_valid;
  hrg_region_t s1_rgn;
  logic [7:0]  s1_frac;
  logic [7:0]  s1_s;
  logic [7:0]  s1_v;
  logic        s1_grey;
  hrg_side_t   s1_side;

  // stage 2 registers
  logic        s2_valid;
  hrg_region_t s2_rgn;
  logic [7:0]  s2_sf;
  logic [7:0]  s2_sfc;
  logic [7:0]  s2_ps;
  logic [7:0]  s2_v;
  logic        s2_grey;
  hrg_side_t   s2_side;

  // stage 3 registers
  logic        s3_valid;
  hrg_region_t s3_rgn;
  logic [7:0]  s3_p;
  logic [7:0]  s3_q;
  logic [7:0]  s3_t;
  logic [7:0]  s3_v;
  logic        s3_grey;
  hrg_side_t   s3_side;

  // stage 4 registers
  logic        s4_valid;
  hrg_px_t     s4_px;

  hrg_region_t rgn_c;
  logic [7:0]  base_c;
  logic [5:0]  diff_c;
  logic [15:0] sf_prod;
  logic [15:0] sfc_prod;
  logic [15:0] p_prod;
  logic [15:0] q_prod;
  logic [15:0] t_prod;
  hrg_px_t     px_c;

  // sector by threshold compare instead of a divide
  always_comb begin
    priority if (hue >= B5) begin
      rgn_c = RGN_MAG_RED; base_c = B5;
    end else if (hue >= B4) begin
      rgn_c = RGN_BLU_MAG; base_c = B4;
    end else if (hue >= B3) begin
      rgn_c = RGN_CYN_BLU; base_c = B3;
    end else if (hue >= B2) begin
      rgn_c = RGN_GRN_CYN; base_c = B2;
    end else if (hue >= B1) begin
      rgn_c = RGN_YEL_GRN; base_c = B1;
    end else begin
      rgn_c = RGN_RED_YEL; base_c = 8'd0;
    end
    diff_c = 6'(hue - base_c);
  end

  always_ff @(posedge clk) begin
    s1_rgn  <= rgn_c;
    s1_frac <= 8'({2'b00, diff_c} * 8'(FRAC_MUL));
    s1_s    <= saturation;
    s1_v    <= brightness;
    s1_grey <= (saturation == 8'd0);
    s1_side <= side_in;
  end

  assign sf_prod  = s1_s * s1_frac;
  assign sfc_prod = s1_s * (FULL - s1_frac);

  always_ff @(posedge clk) begin
    s2_rgn  <= s1_rgn;
    s2_sf   <= sf_prod[15:8];
    s2_sfc  <= sfc_prod[15:8];
    s2_ps   <= FULL - s1_s;
    s2_v    <= s1_v;
    s2_grey <= s1_grey;
    s2_side <= s1_side;
  end

  assign p_prod = s2_v * s2_ps;
  assign q_prod = s2_v * (FULL - s2_sf);
  assign t_prod = s2_v * (FULL - s2_sfc);

  always_ff @(posedge clk) begin
    s3_rgn  <= s2_rgn;
    s3_p    <= p_prod[15:8];
    s3_q    <= q_prod[15:8];
    s3_t    <= t_prod[15:8];
    s3_v    <= s2_v;
    s3_grey <= s2_grey;
    s3_side <= s2_side;
  end

  always_comb begin
    px_c.side = s3_side;
    if (s3_grey) begin
      px_c.r = s3_v; px_c.g = s3_v; px_c.b = s3_v;
    end else begin
      unique case (s3_rgn)
        RGN_RED_YEL: begin px_c.r = s3_v; px_c.g = s3_t; px_c.b = s3_p; end
        RGN_YEL_GRN: begin px_c.r = s3_q; px_c.g = s3_v; px_c.b = s3_p; end
        RGN_GRN_CYN: begin px_c.r = s3_p; px_c.g = s3_v; px_c.b = s3_t; end
        RGN_CYN_BLU: begin px_c.r = s3_p; px_c.g = s3_q; px_c.b = s3_v; end
        RGN_BLU_MAG: begin px_c.r = s3_t; px_c.g = s3_p; px_c.b = s3_v; end
        default: begin px_c.r = s3_v; px_c.g = s3_p; px_c.b = s3_q; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s4_px <= px_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  assign out_valid = s4_valid;
  assign out_px    = s4_px;

endmodule

// ===== sv/hsv_to_rgb_gamma_scale_top.sv =====
// top level: hsv pipeline, gamma table stage and video scale stage
//
// channel   signals                                          direction  handshake
// command   start, busy, hue, saturation, brightness,        in         start && !busy
//           scale_enable, scale
// result    strobe, red, green, blue                         out        strobe, one cycle
//
// one pixel enters every cycle; busy is always low since nothing downstream can stall
// a result shows on strobe once its transfer has passed the sector stage, the two multiplier
// stages of the p/q/t terms, then the select, gamma and scale stages
// reset clears only the valid bits travelling with the data
module hsv_to_rgb_gamma_scale_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  input  logic       scale_enable,
  input  logic [7:0] scale,
  output logic       strobe,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);
  import hrg_pkg::*;

  hrg_side_t   side_in;
  logic        hsv_valid;
  hrg_px_t     hsv_px;

  logic        g_valid;
  hrg_px_t     g_px;

  logic        o_valid;
  logic [7:0]  o_r;
  logic [7:0]  o_g;
  logic [7:0]  o_b;

  logic [15:0] r_prod;
  logic [15:0] g_prod;
  logic [15:0] b_prod;
  logic [7:0]  r_next;
  logic [7:0]  g_next;
  logic [7:0]  b_next;

  assign busy       = 1'b0;
  assign side_in.en = scale_enable;
  assign side_in.k  = scale;

  hrg_hsv_pipe u_hsv (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .side_in    (side_in),
    .out_valid  (hsv_valid),
    .out_px     (hsv_px)
  );

  always_ff @(posedge clk) begin
    g_px.r    <= GAMMA_ROM[hsv_px.r];
    g_px.g    <= GAMMA_ROM[hsv_px.g];
    g_px.b    <= GAMMA_ROM[hsv_px.b];
    g_px.side <= hsv_px.side;
  end

  assign r_prod = g_px.r * g_px.side.k;
  assign g_prod = g_px.g * g_px.side.k;
  assign b_prod = g_px.b * g_px.side.k;

  // a lit channel never scales down to dark
  always_comb begin
    r_next = g_px.r;
    g_next = g_px.g;
    b_next = g_px.b;
    if (g_px.side.en) begin
      r_next = (g_px.r != 8'd0 && r_prod[15:8] == 8'd0) ? 8'd1 : r_prod[15:8];
      g_next = (g_px.g != 8'd0 && g_prod[15:8] == 8'd0) ? 8'd1 : g_prod[15:8];
      b_next = (g_px.b != 8'd0 && b_prod[15:8] == 8'd0) ? 8'd1 : b_prod[15:8];
    end
  end

  always_ff @(posedge clk) begin
    o_r <= r_next;
    o_g <= g_next;
    o_b <= b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      g_valid <= hsv_valid;
      o_valid <= g_valid;
    end
  end

  assign strobe = o_valid;
  assign red    = o_r;
  assign green  = o_g;
  assign blue   = o_b;

endmodule

// ===== sv/hrg_checker.sv =====
// port-level checks for the hsv to rgb top, bound to every instance
module hrg_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] saturation,
  input logic [7:0] brightness,
  input logic       strobe,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  localparam int unsigned LAT = 6;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT strobe)
    else $error("transfer lost in pipeline");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, LAT))
    else $error("result without a transfer");

  // zero saturation gives grey, scaled or not
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && saturation == 8'd0) |-> ##LAT (red == green && green == blue))
    else $error("grey pixel lost its balance");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && brightness == 8'd0) |->
      ##LAT (red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("black pixel lit");

endmodule

bind hsv_to_rgb_gamma_scale_top hrg_checker u_hrg_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .saturation (saturation),
  .brightness (brightness),
  .strobe     (strobe),
  .red        (red),
  .green      (green),
  .blue       (blue)
);
